// File: rtl/twns_pkg.sv
// Package: shared constants, codes and types of the texture sampler.
`timescale 1ns / 1ps
package twns_pkg;

  localparam int STORE_BYTES_DEF = 262144;
  localparam int COORD_FRAC_DEF  = 16;

  localparam int COORD_W = 24;
  localparam int IDX_W   = 11;
  localparam int CHAN_W  = 3;
  localparam int ADDR_W  = 18;
  localparam int BYTE_W  = 8;
  localparam int PROD_W  = 2 * IDX_W;
  localparam int LOC_W   = PROD_W + 1 + CHAN_W;
  localparam int BANKS   = 4;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  localparam logic [1:0] WRAP_CLAMP  = 2'd0;
  localparam logic [1:0] WRAP_REPEAT = 2'd1;
  localparam logic [1:0] WRAP_MIRROR = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_MOD = 2'd1;
  localparam logic [1:0] ST_BEYOND   = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CHAN   = 2'd2;

  localparam logic [IDX_W-1:0]  WIDTH_RST  = 11'd256;
  localparam logic [IDX_W-1:0]  HEIGHT_RST = 11'd256;
  localparam logic [CHAN_W-1:0] CHAN_RST   = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0]  width;
    logic [IDX_W-1:0]  height;
    logic [CHAN_W-1:0] chan;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
  } side_t;

  typedef struct packed {
    logic              valid;
    logic              mode;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [IDX_W-1:0]  tx;
    logic [IDX_W-1:0]  ty;
    logic              zmod;
  } fetch_in_t;

endpackage

// File: rtl/twns_in_if.sv
// Interface: input channel carrying write and sample beats.
`timescale 1ns / 1ps
interface twns_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [23:0] u_coord;
  logic [23:0] v_coord;
  logic [1:0]  wrap_mode;
  logic [17:0] byte_address;
  logic [7:0]  byte_data;

  modport source (output valid, mode, u_coord, v_coord, wrap_mode, byte_address, byte_data,
                  input ready);
  modport sink (input valid, mode, u_coord, v_coord, wrap_mode, byte_address, byte_data,
                output ready);
endinterface

// File: rtl/twns_out_if.sv
// Interface: result channel carrying texel color beats.
`timescale 1ns / 1ps
interface twns_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [1:0] status;

  modport source (output valid, red, green, blue, status, input ready);
  modport sink (input valid, red, green, blue, status, output ready);
endinterface

// File: rtl/texture_wrap_nearest_sampler.sv
// Top level: texture sampler with wrap modes and nearest filtering.
`timescale 1ns / 1ps
// Usage:
//   in_ch  : write beats (mode 0) store one byte; sample beats (mode 1)
//            carry u/v in unsigned fixed point and a wrap mode.
//   out_ch : one beat per sample: red, green, blue and a status code.
//            Write beats produce no result.
//   APB    : width, height and channel count at 0x0, 0x4, 0x8; change
//            them only while no beat is in flight.
// A sample's pipeline depth is set by the one-bit-per-stage modulo and so
//   grows as COORD_FRACTION_BITS shrinks.
// Throughput: one beat per cycle unless out_ch stalls; writes and samples
//   share the pipeline and reach the four byte banks in order, so a
//   sample sees every earlier write.
// Reset clears all valid bits and returns the APB registers to their reset
//   values; the byte store is not cleared. When out_ch stalls the whole
//   pipeline holds and in_ch.ready drops; nothing is lost or repeated.
module texture_wrap_nearest_sampler #(
  parameter int STORE_BYTES         = twns_pkg::STORE_BYTES_DEF,
  parameter int COORD_FRACTION_BITS = twns_pkg::COORD_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  twns_in_if.sink                     in_ch,
  twns_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twns_pkg::CFG_AW-1:0] paddr,
  input  logic [twns_pkg::CFG_DW-1:0] pwdata,
  output logic [twns_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import twns_pkg::*;

  localparam int AX_LAT = COORD_W - COORD_FRACTION_BITS + 2;

  cfg_t             cfg;
  logic             adv;
  logic [IDX_W-1:0] maxx, maxy, tx, ty;
  logic             zx, zy;
  side_t            sb_r [0:AX_LAT-1];
  fetch_in_t        fin;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign maxx        = cfg.width - IDX_W'(1);
  assign maxy        = cfg.height - IDX_W'(1);

  twns_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  twns_axis #(.COORD_FRACTION_BITS(COORD_FRACTION_BITS)) u_axis_x (
    .clk   (clk),
    .adv   (adv),
    .coord (in_ch.u_coord),
    .maxv  (maxx),
    .wrap  (in_ch.wrap_mode),
    .idx   (tx),
    .zmod  (zx)
  );

  twns_axis #(.COORD_FRACTION_BITS(COORD_FRACTION_BITS)) u_axis_y (
    .clk   (clk),
    .adv   (adv),
    .coord (in_ch.v_coord),
    .maxv  (maxy),
    .wrap  (in_ch.wrap_mode),
    .idx   (ty),
    .zmod  (zy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AX_LAT; i++) begin
        sb_r[i].valid <= 1'b0;
      end
    end else if (adv) begin
      sb_r[0].valid <= in_ch.valid;
      sb_r[0].mode  <= in_ch.mode;
      sb_r[0].waddr <= in_ch.byte_address;
      sb_r[0].wdata <= in_ch.byte_data;
      for (int i = 1; i < AX_LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign fin.valid = sb_r[AX_LAT-1].valid;
  assign fin.mode  = sb_r[AX_LAT-1].mode;
  assign fin.waddr = sb_r[AX_LAT-1].waddr;
  assign fin.wdata = sb_r[AX_LAT-1].wdata;
  assign fin.tx    = tx;
  assign fin.ty    = ty;
  assign fin.zmod  = zx || zy || (cfg.width == '0) || (cfg.height == '0);

  twns_fetch #(.STORE_BYTES(STORE_BYTES)) u_fetch (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .cfg    (cfg),
    .fin    (fin),
    .out_ch (out_ch)
  );

endmodule

// File: rtl/twns_cfg.sv
// APB register file: texture width, height and channel count.
`timescale 1ns / 1ps
module twns_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [twns_pkg::CFG_AW-1:0] paddr,
  input  logic [twns_pkg::CFG_DW-1:0] pwdata,
  output logic [twns_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output twns_pkg::cfg_t              cfg
);
  import twns_pkg::*;

  logic [IDX_W-1:0]  width_r;
  logic [IDX_W-1:0]  height_r;
  logic [CHAN_W-1:0] chan_r;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      chan_r   <= CHAN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:  width_r  <= pwdata[IDX_W-1:0];
        REG_HEIGHT: height_r <= pwdata[IDX_W-1:0];
        REG_CHAN:   chan_r   <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = CFG_DW'(width_r);
      REG_HEIGHT: prdata = CFG_DW'(height_r);
      REG_CHAN:   prdata = CFG_DW'(chan_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;
  assign cfg.chan   = chan_r;

endmodule

// File: rtl/twns_axis.sv
// Axis pipeline: coordinate scale, one-bit-per-stage modulo, wrap select.
`timescale 1ns / 1ps
module twns_axis #(
  parameter int COORD_FRACTION_BITS = twns_pkg::COORD_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [twns_pkg::COORD_W-1:0] coord,
  input  logic [twns_pkg::IDX_W-1:0]   maxv,
  input  logic [1:0]                   wrap,
  output logic [twns_pkg::IDX_W-1:0]   idx,
  output logic                         zmod
);
  import twns_pkg::*;

  localparam int IB = COORD_W - COORD_FRACTION_BITS;
  localparam int PW = COORD_W + IDX_W;
  localparam int TW = PW - COORD_FRACTION_BITS;

  logic [TW-1:0]    rem_r  [0:IB];
  logic [1:0]       wrap_r [0:IB];
  logic             par_r  [0:IB];
  logic [PW-1:0]    prod;
  logic [COORD_W:0] ipart;
  logic [TW-1:0]    t_last;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             zmod_r, zmod_nxt;

  assign prod  = PW'(coord) * PW'(maxv);
  assign ipart = {1'b0, coord} >> COORD_FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= prod[PW-1:COORD_FRACTION_BITS];
      wrap_r[0] <= wrap;
      par_r[0]  <= ipart[0];
    end
  end

  for (genvar i = 1; i <= IB; i++) begin : g_div
    logic [TW-1:0] dvs;
    logic          rm;
    assign dvs = TW'(maxv) << (IB - i);
    assign rm  = (wrap_r[i-1] == WRAP_REPEAT) || (wrap_r[i-1] == WRAP_MIRROR);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= (rm && rem_r[i-1] >= dvs) ? rem_r[i-1] - dvs : rem_r[i-1];
        wrap_r[i] <= wrap_r[i-1];
        par_r[i]  <= par_r[i-1];
      end
    end
  end

  assign t_last = rem_r[IB];

  always_comb begin
    unique case (wrap_r[IB])
      WRAP_REPEAT: begin
        idx_nxt  = IDX_W'(t_last);
        zmod_nxt = (maxv == '0);
      end
      WRAP_MIRROR: begin
        idx_nxt  = par_r[IB] ? maxv - IDX_W'(t_last) : IDX_W'(t_last);
        zmod_nxt = (maxv == '0);
      end
      default: begin
        idx_nxt  = (t_last > TW'(maxv)) ? maxv : IDX_W'(t_last);
        zmod_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r  <= idx_nxt;
      zmod_r <= zmod_nxt;
    end
  end

  assign idx  = idx_r;
  assign zmod = zmod_r;

endmodule

// File: rtl/twns_fetch.sv
// Fetch pipeline: byte address, four interleaved byte banks, color output.
`timescale 1ns / 1ps
module twns_fetch #(
  parameter int STORE_BYTES = twns_pkg::STORE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  twns_pkg::cfg_t      cfg,
  input  twns_pkg::fetch_in_t fin,
  twns_out_if.source          out_ch
);
  import twns_pkg::*;

  localparam int BANK_DEPTH = (STORE_BYTES + BANKS - 1) / BANKS;
  localparam int BI_W       = $clog2(BANK_DEPTH);

  // stage 1
  logic              v1_r, smp1_r, zm1_r;
  logic [ADDR_W-1:0] wa1_r;
  logic [BYTE_W-1:0] wd1_r;
  logic [IDX_W-1:0]  tx1_r;
  logic [PROD_W-1:0] p1_r;
  // stage 2
  logic              v2_r, smp2_r, zm2_r;
  logic [ADDR_W-1:0] wa2_r;
  logic [BYTE_W-1:0] wd2_r;
  logic [LOC_W-1:0]  loc2_r;
  logic [PROD_W:0]   lin;
  // stage 3
  logic              v3_r, smp3_r;
  logic [1:0]        st3_r, st_nxt;
  logic [1:0]        lane3_r;
  logic [BYTE_W-1:0] rd_r [0:BANKS-1];
  logic              beyond;
  logic [31:0]       wa32;
  logic              wr_ok;
  // output
  logic              ov_r;
  logic [BYTE_W-1:0] red_r, green_r, blue_r;
  logic [BYTE_W-1:0] red_nxt, green_nxt, blue_nxt;
  logic [1:0]        st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= fin.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r && smp3_r;
    end
  end

  assign lin = (PROD_W + 1)'(tx1_r) + (PROD_W + 1)'(p1_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      smp1_r <= (fin.mode == MODE_SAMPLE);
      zm1_r  <= fin.zmod;
      wa1_r  <= fin.waddr;
      wd1_r  <= fin.wdata;
      tx1_r  <= fin.tx;
      p1_r   <= PROD_W'(fin.ty) * PROD_W'(cfg.width);
      smp2_r <= smp1_r;
      zm2_r  <= zm1_r;
      wa2_r  <= wa1_r;
      wd2_r  <= wd1_r;
      loc2_r <= LOC_W'(lin) * LOC_W'(cfg.chan);
    end
  end

  assign beyond = (32'(loc2_r) + 32'd2) >= 32'(STORE_BYTES);
  assign st_nxt = zm2_r ? ST_ZERO_MOD : (beyond ? ST_BEYOND : ST_OK);
  assign wa32   = 32'(wa2_r);
  assign wr_ok  = adv && v2_r && !smp2_r && (wa32 < 32'(STORE_BYTES));

  for (genvar k = 0; k < BANKS; k++) begin : g_bank
    localparam logic [1:0] K = 2'(k);
    logic [BYTE_W-1:0] mem [0:BANK_DEPTH-1];
    logic [1:0]        off;
    logic [LOC_W:0]    ak;
    logic [BI_W-1:0]   ridx, widx;
    assign off  = K - loc2_r[1:0];
    assign ak   = (LOC_W + 1)'(loc2_r) + (LOC_W + 1)'(off);
    assign ridx = ak[BI_W+1:2];
    assign widx = wa32[BI_W+1:2];
    always_ff @(posedge clk) begin
      if (wr_ok && wa2_r[1:0] == K) begin
        mem[widx] <= wd2_r;
      end
      if (adv) begin
        rd_r[k] <= mem[ridx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp3_r  <= smp2_r;
      st3_r   <= st_nxt;
      lane3_r <= loc2_r[1:0];
    end
  end

  always_comb begin
    unique case (lane3_r)
      2'd0: begin red_nxt = rd_r[0]; green_nxt = rd_r[1]; blue_nxt = rd_r[2]; end
      2'd1: begin red_nxt = rd_r[1]; green_nxt = rd_r[2]; blue_nxt = rd_r[3]; end
      2'd2: begin red_nxt = rd_r[2]; green_nxt = rd_r[3]; blue_nxt = rd_r[0]; end
      default: begin red_nxt = rd_r[3]; green_nxt = rd_r[0]; blue_nxt = rd_r[1]; end
    endcase
    if (st3_r != ST_OK) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      st_r    <= st3_r;
    end
  end

  assign out_ch.valid  = ov_r;
  assign out_ch.red    = red_r;
  assign out_ch.green  = green_r;
  assign out_ch.blue   = blue_r;
  assign out_ch.status = st_r;

`ifndef NO_ASSERTIONS
  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && st_r != ST_OK |-> red_r == '0 && green_r == '0 && blue_r == '0)
    else $error("error beat carries color");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (st_r == ST_OK || st_r == ST_ZERO_MOD || st_r == ST_BEYOND))
    else $error("bad status code");
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v3_r && !smp3_r |=> !ov_r)
    else $error("write beat produced a result");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v3_r) && $stable(lane3_r) && $stable(st3_r))
    else $error("fetch stage moved during stall");
`endif

endmodule

// File: tb/sv/texture_wrap_nearest_sampler_test.sv
// Testbench: self-checking random and directed test of the texture sampler.
`timescale 1ns / 1ps
module texture_wrap_nearest_sampler_test;
  import twns_pkg::*;

  typedef struct {
    bit        mode;
    bit [23:0] u;
    bit [23:0] v;
    bit [1:0]  wrap;
    bit [17:0] addr;
    bit [7:0]  data;
  } tex_beat_t;

  typedef struct {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [1:0] status;
  } texel_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata, prdata;

  twns_in_if  in_ch ();
  twns_out_if out_ch ();

  texture_wrap_nearest_sampler uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  bit [7:0]  texel_mem [int];
  bit        gen_written [int];
  longint    cfg_w, cfg_h, cfg_ch;
  tex_beat_t beat_q[$];
  texel_t    texel_q[$];
  int        beats_in;
  int        mismatches;
  int        stall_left;
  int        send_idle, recv_idle;

  function automatic bit wrap_index(input longint c, input longint m, input bit [1:0] wm,
                                    output longint t);
    t = (c * m) >> COORD_FRAC_DEF;
    if (wm == WRAP_REPEAT || wm == WRAP_MIRROR) begin
      if (m == 0) return 1'b0;
      t = t % m;
      if (wm == WRAP_MIRROR && ((c >> COORD_FRAC_DEF) & 1)) t = m - t;
    end else if (t > m) begin
      t = m;
    end
    return 1'b1;
  endfunction

  function automatic bit [1:0] texel_loc(input bit [23:0] u, input bit [23:0] v,
                                         input bit [1:0] wm, output longint loc);
    longint tx, ty;
    loc = 0;
    if (cfg_w == 0 || cfg_h == 0) return ST_ZERO_MOD;
    if (!wrap_index(u, cfg_w - 1, wm, tx) || !wrap_index(v, cfg_h - 1, wm, ty))
      return ST_ZERO_MOD;
    loc = (tx + ty * cfg_w) * cfg_ch;
    if (loc + 2 >= STORE_BYTES_DEF) return ST_BEYOND;
    return ST_OK;
  endfunction

  function automatic void apply_beat(input tex_beat_t b);
    texel_t e;
    longint loc;
    if (b.mode == MODE_WRITE) begin
      texel_mem[b.addr] = b.data;
      return;
    end
    e = '{8'd0, 8'd0, 8'd0, ST_OK};
    e.status = texel_loc(b.u, b.v, b.wrap, loc);
    if (e.status == ST_OK) begin
      e.red   = texel_mem[int'(loc)];
      e.green = texel_mem[int'(loc + 1)];
      e.blue  = texel_mem[int'(loc + 2)];
    end
    texel_q.push_back(e);
  endfunction

  function automatic void push_write(input int addr, input bit [7:0] data);
    tex_beat_t b;
    b.mode = MODE_WRITE;
    b.u = 24'($urandom);
    b.v = 24'($urandom);
    b.wrap = 2'($urandom_range(3));
    b.addr = 18'(addr);
    b.data = data;
    gen_written[addr] = 1'b1;
    beat_q.push_back(b);
  endfunction

  // a sample whose texel bytes are not yet loaded gets writes queued ahead of it
  function automatic void push_sample(input bit [23:0] u, input bit [23:0] v,
                                      input bit [1:0] wm);
    tex_beat_t b;
    longint loc;
    if (texel_loc(u, v, wm, loc) == ST_OK)
      for (int k = 0; k < 3; k++)
        if (!gen_written.exists(int'(loc + k))) push_write(int'(loc + k), 8'($urandom));
    b.mode = MODE_SAMPLE;
    b.u = u;
    b.v = v;
    b.wrap = wm;
    b.addr = 18'($urandom);
    b.data = 8'($urandom);
    beat_q.push_back(b);
  endfunction

  function automatic bit [23:0] rand_coord();
    bit [23:0] c;
    case ($urandom_range(3))
      0: c = {6'd0, 2'($urandom_range(3)), 16'($urandom)};
      1: case ($urandom_range(3))
           0: c = 24'h000000;
           1: c = 24'hFFFFFF;
           2: c = 24'h010000;
           default: c = 24'h00FFFF;
         endcase
      default: c = 24'($urandom);
    endcase
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        apply_beat('{in_ch.mode, in_ch.u_coord, in_ch.v_coord, in_ch.wrap_mode,
                     in_ch.byte_address, in_ch.byte_data});
        beats_in++;
      end
      send_idle = beats_in < 620 ? 38 : beats_in < 1240 ? 74 : 0;
      recv_idle = beats_in < 620 ? 74 : beats_in < 1240 ? 38 : 0;
      if (!in_ch.valid || in_ch.ready) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          tex_beat_t b;
          b = beat_q.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.mode         <= b.mode;
          in_ch.u_coord      <= b.u;
          in_ch.v_coord      <= b.v;
          in_ch.wrap_mode    <= b.wrap;
          in_ch.byte_address <= b.addr;
          in_ch.byte_data    <= b.data;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk)
    if (stall_left > 0) stall_left <= stall_left - 1;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (texel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat status %0d", out_ch.status);
        end else begin
          texel_t e;
          e = texel_q.pop_front();
          if (out_ch.red !== e.red || out_ch.green !== e.green || out_ch.blue !== e.blue ||
              out_ch.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp rgb %h %h %h st %0d, got %h %h %h st %0d",
                       e.red, e.green, e.blue, e.status,
                       out_ch.red, out_ch.green, out_ch.blue, out_ch.status);
          end
        end
      end
      out_ch.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input int value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_w  = value & 32'h7FF;
      REG_HEIGHT: cfg_h  = value & 32'h7FF;
      default:    cfg_ch = value & 32'h7;
    endcase
  endtask

  task automatic drain();
    while (beat_q.size() > 0 || in_ch.valid || texel_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  int phase_w[8]  = '{256, 1, 1024, 0, 2047, 16, 3, 5};
  int phase_h[8]  = '{256, 1, 1024, 7, 2047, 8, 1024, 1};
  int phase_ch[8] = '{4, 3, 4, 3, 7, 0, 4, 3};

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_WRITE;
    in_ch.u_coord = '0;
    in_ch.v_coord = '0;
    in_ch.wrap_mode = WRAP_CLAMP;
    in_ch.byte_address = '0;
    in_ch.byte_data = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    stall_left = 0;
    beats_in = 0;
    mismatches = 0;
    cfg_w = WIDTH_RST;
    cfg_h = HEIGHT_RST;
    cfg_ch = CHAN_RST;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: store extremes, coordinate extremes, every wrap incl. unused code
    push_write(0, 8'h00);
    push_write(1, 8'hFF);
    push_write(2, 8'hA5);
    push_write(262143, 8'hFF);
    for (int w = 0; w < 4; w++) begin
      push_sample(24'h000000, 24'h000000, 2'(w));
      push_sample(24'hFFFFFF, 24'hFFFFFF, 2'(w));
      push_sample(24'h010000, 24'h00FFFF, 2'(w));
      push_sample(24'h018000, 24'h030000, 2'(w));
    end

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        reg_write(REG_WIDTH, phase_w[p]);
        reg_write(REG_HEIGHT, phase_h[p]);
        reg_write(REG_CHAN, phase_ch[p]);
      end
      while (beat_q.size() < 230) begin
        if ($urandom_range(9) < 2) push_write($urandom_range(262143), 8'($urandom));
        else push_sample(rand_coord(), rand_coord(),
                         $urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2)));
      end
      if (p == 2) begin
        repeat (10) @(posedge clk);
        stall_left <= 300;
      end
      drain();
    end

    if (mismatches == 0 && texel_q.size() == 0)
      $display("texture_wrap_nearest_sampler_test OK");
    else
      $display("texture_wrap_nearest_sampler_test NOT OK");
    $finish;
  end

  initial begin
    #4000000;
    $display("texture_wrap_nearest_sampler_test NOT OK");
    $finish;
  end
endmodule

// File: filelist.f
rtl/twns_pkg.sv
rtl/twns_in_if.sv
rtl/twns_out_if.sv
rtl/twns_cfg.sv
rtl/twns_axis.sv
rtl/twns_fetch.sv
rtl/texture_wrap_nearest_sampler.sv
tb/sv/texture_wrap_nearest_sampler_test.sv
